/* rtl/lsp_pkg.sv */
`timescale 1ns / 1ps

package lsp_pkg;

    // Field widths
    localparam int TimeW     = 32;
    localparam int IntervalW = 16;
    localparam int ModeW     = 3;
    localparam int PhaseW    = 2;
    localparam int CountW    = 2;
    localparam int CfgAddrW  = 3;
    localparam int CfgDataW  = 16;
    localparam int InDataW   = 32;
    localparam int OutDataW  = 8;

    // Register indexes on the configuration port
    localparam logic [CfgAddrW-1:0] REG_MODE      = 3'd0;
    localparam logic [CfgAddrW-1:0] REG_FAST_HALF = 3'd1;
    localparam logic [CfgAddrW-1:0] REG_SLOW_HALF = 3'd2;
    localparam logic [CfgAddrW-1:0] REG_FAIL_HALF = 3'd3;
    localparam logic [CfgAddrW-1:0] REG_OK_PAUSE  = 3'd4;
    localparam logic [CfgAddrW-1:0] REG_OK_LONG   = 3'd5;
    localparam logic [CfgAddrW-1:0] REG_OK_HOLD   = 3'd6;

    // Mode codes
    localparam logic [ModeW-1:0] MODE_OFF  = 3'd0;
    localparam logic [ModeW-1:0] MODE_ON   = 3'd1;
    localparam logic [ModeW-1:0] MODE_FAST = 3'd2;
    localparam logic [ModeW-1:0] MODE_SLOW = 3'd3;
    localparam logic [ModeW-1:0] MODE_FAIL = 3'd4;
    localparam logic [ModeW-1:0] MODE_OK   = 3'd5;

    // OK pattern phases
    localparam logic [PhaseW-1:0] PH_BURST  = 2'd0;
    localparam logic [PhaseW-1:0] PH_PAUSE  = 2'd1;
    localparam logic [PhaseW-1:0] PH_PULSES = 2'd2;
    localparam logic [PhaseW-1:0] PH_HOLD   = 2'd3;

    localparam logic [CountW-1:0] OK_BURSTS   = 2'd3;
    localparam logic [CountW-1:0] PULSE_LONG  = 2'd1;
    localparam logic [CountW-1:0] PULSE_LAST  = 2'd2;

    // Reset values of the interval registers
    localparam logic [IntervalW-1:0] RST_FAST_HALF = 16'd200;
    localparam logic [IntervalW-1:0] RST_SLOW_HALF = 16'd1000;
    localparam logic [IntervalW-1:0] RST_FAIL_HALF = 16'd2000;
    localparam logic [IntervalW-1:0] RST_OK_PAUSE  = 16'd500;
    localparam logic [IntervalW-1:0] RST_OK_LONG   = 16'd600;
    localparam logic [IntervalW-1:0] RST_OK_HOLD   = 16'd1000;

    // Interval settings handed from the register file to the engine
    typedef struct packed {
        logic [IntervalW-1:0] fast_half;
        logic [IntervalW-1:0] slow_half;
        logic [IntervalW-1:0] fail_half;
        logic [IntervalW-1:0] ok_pause;
        logic [IntervalW-1:0] ok_long;
        logic [IntervalW-1:0] ok_hold;
    } lsp_intervals_t;

    // Mode write from the configuration port
    typedef struct packed {
        logic             wr;
        logic [ModeW-1:0] mode;
    } lsp_mode_wr_t;

endpackage

/* rtl/lsp_cfg_regs.sv */
`timescale 1ns / 1ps

module lsp_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [lsp_pkg::CfgAddrW-1:0]   cfg_addr,
    input  logic [lsp_pkg::CfgDataW-1:0]   cfg_wr_data,
    output lsp_pkg::lsp_intervals_t        intervals,
    output lsp_pkg::lsp_mode_wr_t          mode_wr
);
    import lsp_pkg::*;

    lsp_intervals_t intervals_reg;
    lsp_intervals_t intervals_next;

    // Register decode; unknown indexes are dropped
    always_comb begin
        intervals_next = intervals_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_FAST_HALF: intervals_next.fast_half = cfg_wr_data;
                REG_SLOW_HALF: intervals_next.slow_half = cfg_wr_data;
                REG_FAIL_HALF: intervals_next.fail_half = cfg_wr_data;
                REG_OK_PAUSE:  intervals_next.ok_pause  = cfg_wr_data;
                REG_OK_LONG:   intervals_next.ok_long   = cfg_wr_data;
                REG_OK_HOLD:   intervals_next.ok_hold   = cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            intervals_reg.fast_half <= RST_FAST_HALF;
            intervals_reg.slow_half <= RST_SLOW_HALF;
            intervals_reg.fail_half <= RST_FAIL_HALF;
            intervals_reg.ok_pause  <= RST_OK_PAUSE;
            intervals_reg.ok_long   <= RST_OK_LONG;
            intervals_reg.ok_hold   <= RST_OK_HOLD;
        end else begin
            intervals_reg <= intervals_next;
        end
    end

    assign intervals    = intervals_reg;
    // The mode register only loads the active mode in the engine
    assign mode_wr.wr   = cfg_wr_en && (cfg_addr == REG_MODE);
    assign mode_wr.mode = cfg_wr_data[ModeW-1:0];

endmodule

/* rtl/lsp_engine.sv */
`timescale 1ns / 1ps

module lsp_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step_en,
    input  logic [lsp_pkg::TimeW-1:0]     now_ms,
    input  lsp_pkg::lsp_intervals_t       intervals,
    input  lsp_pkg::lsp_mode_wr_t         mode_wr,
    output logic                          led_next
);
    import lsp_pkg::*;

    logic [ModeW-1:0]  active_mode_reg,    active_mode_next;
    logic              pin_level_reg,      pin_level_next;
    logic              blink_level_reg,    blink_level_next;
    logic [TimeW-1:0]  last_toggle_reg,    last_toggle_next;
    logic [PhaseW-1:0] ok_phase_reg,       ok_phase_next;
    logic [CountW-1:0] ok_burst_count_reg, ok_burst_count_next;
    logic [CountW-1:0] ok_pulse_index_reg, ok_pulse_index_next;
    logic              ok_level_reg,       ok_level_next;
    logic [TimeW-1:0]  ok_finish_reg,      ok_finish_next;

    logic [TimeW-1:0]     base_ms;
    logic [TimeW-1:0]     elapsed;
    logic [IntervalW-1:0] limit;
    logic                 due;
    logic                 ok_lvl_t;
    logic [CountW-1:0]    cnt_t;

    // One wrapping subtract: hold phase measures from the finish time
    assign base_ms = (active_mode_reg == MODE_OK && ok_phase_reg == PH_HOLD)
                     ? ok_finish_reg : last_toggle_reg;
    assign elapsed = now_ms - base_ms;

    // Interval that applies to the current mode and phase
    always_comb begin
        limit = intervals.fast_half;
        unique case (active_mode_reg)
            MODE_SLOW: limit = intervals.slow_half;
            MODE_FAIL: limit = intervals.fail_half;
            MODE_OK: begin
                unique case (ok_phase_reg)
                    PH_BURST:  limit = intervals.fast_half;
                    PH_PAUSE:  limit = intervals.ok_pause;
                    PH_PULSES: limit = (ok_pulse_index_reg == PULSE_LONG)
                                       ? intervals.ok_long : intervals.fast_half;
                    default:   limit = intervals.ok_hold;
                endcase
            end
            default: limit = intervals.fast_half;
        endcase
    end

    assign due = (elapsed >= {{(TimeW-IntervalW){1'b0}}, limit});

    // Per-poll state update
    always_comb begin
        active_mode_next    = active_mode_reg;
        pin_level_next      = pin_level_reg;
        blink_level_next    = blink_level_reg;
        last_toggle_next    = last_toggle_reg;
        ok_phase_next       = ok_phase_reg;
        ok_burst_count_next = ok_burst_count_reg;
        ok_pulse_index_next = ok_pulse_index_reg;
        ok_level_next       = ok_level_reg;
        ok_finish_next      = ok_finish_reg;
        ok_lvl_t            = ~ok_level_reg;
        cnt_t               = ok_burst_count_reg;

        unique case (active_mode_reg)
            MODE_OFF: pin_level_next = 1'b0;
            MODE_ON:  pin_level_next = 1'b1;
            MODE_FAST, MODE_SLOW, MODE_FAIL: begin
                if (due) begin
                    blink_level_next = ~blink_level_reg;
                    pin_level_next   = ~blink_level_reg;
                    last_toggle_next = now_ms;
                end
            end
            MODE_OK: begin
                unique case (ok_phase_reg)
                    PH_BURST: begin
                        if (due) begin
                            ok_level_next    = ok_lvl_t;
                            pin_level_next   = ok_lvl_t;
                            last_toggle_next = now_ms;
                            cnt_t = ok_lvl_t ? ok_burst_count_reg
                                             : ok_burst_count_reg + 2'd1;
                            if (cnt_t >= OK_BURSTS) begin
                                ok_phase_next       = PH_PAUSE;
                                ok_burst_count_next = '0;
                            end else begin
                                ok_burst_count_next = cnt_t;
                            end
                        end
                    end
                    PH_PAUSE: begin
                        if (due) begin
                            ok_phase_next       = PH_PULSES;
                            ok_pulse_index_next = '0;
                            ok_level_next       = 1'b0;
                            pin_level_next      = 1'b0;
                            last_toggle_next    = now_ms;
                        end
                    end
                    PH_PULSES: begin
                        if (due) begin
                            ok_level_next    = ok_lvl_t;
                            pin_level_next   = ok_lvl_t;
                            last_toggle_next = now_ms;
                            cnt_t = ok_lvl_t ? ok_pulse_index_reg
                                             : ok_pulse_index_reg + 2'd1;
                            ok_pulse_index_next = cnt_t;
                            if (cnt_t > PULSE_LAST) begin
                                ok_phase_next  = PH_HOLD;
                                ok_finish_next = now_ms;
                                pin_level_next = 1'b0;
                            end
                        end
                    end
                    default: begin
                        if (due) begin
                            active_mode_next = MODE_ON;
                        end
                    end
                endcase
            end
            default: ;
        endcase
    end

    assign led_next = pin_level_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_mode_reg    <= MODE_OFF;
            pin_level_reg      <= 1'b0;
            blink_level_reg    <= 1'b0;
            last_toggle_reg    <= '0;
            ok_phase_reg       <= PH_BURST;
            ok_burst_count_reg <= '0;
            ok_pulse_index_reg <= '0;
            ok_level_reg       <= 1'b0;
            ok_finish_reg      <= '0;
        end else if (mode_wr.wr) begin
            active_mode_reg <= mode_wr.mode;
        end else if (step_en) begin
            active_mode_reg    <= active_mode_next;
            pin_level_reg      <= pin_level_next;
            blink_level_reg    <= blink_level_next;
            last_toggle_reg    <= last_toggle_next;
            ok_phase_reg       <= ok_phase_next;
            ok_burst_count_reg <= ok_burst_count_next;
            ok_pulse_index_reg <= ok_pulse_index_next;
            ok_level_reg       <= ok_level_next;
            ok_finish_reg      <= ok_finish_next;
        end
    end

    // Pulse index is never seen past its terminal value outside the hold phase
    a_pulse_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (ok_phase_reg != PH_HOLD) |-> (ok_pulse_index_reg != 2'd3))
        else $error("pulse index beyond last pulse outside hold");

    // Burst count never reaches the burst limit while stored
    a_burst_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ok_burst_count_reg != OK_BURSTS)
        else $error("burst count stored at limit");

    // A poll in hold phase keeps the level last driven
    a_hold_steady: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && active_mode_reg == MODE_OK && ok_phase_reg == PH_HOLD
         && !mode_wr.wr) |=> $stable(pin_level_reg))
        else $error("LED level changed during OK hold");

endmodule

/* rtl/led_status_pattern.sv */
`timescale 1ns / 1ps

// Channel   Direction  Transaction payload
// s_axis    in         tdata[31:0] now_ms
// m_axis    out        tdata[0] led_level, tdata[7:1] zero
// cfg       in         cfg_addr register index, cfg_wr_data value
//
// One poll per cycle sustained while m_tready is high; from s_ accept to m_tvalid
// a poll passes the input register, then the state update into the result register.
// The state update is one 32-bit subtract and compare per poll.
// aresetn is synchronous, active low: intervals go to their defaults, mode off.
// A stalled result holds in the output register while the next poll waits in
// the input register; s_tready drops only when both are full.
module led_status_pattern (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lsp_pkg::InDataW-1:0]    s_tdata,      // [31:0] now_ms
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lsp_pkg::OutDataW-1:0]   m_tdata,      // [0] led_level
    input  logic                           cfg_wr_en,
    input  logic [lsp_pkg::CfgAddrW-1:0]   cfg_addr,
    input  logic [lsp_pkg::CfgDataW-1:0]   cfg_wr_data
);
    import lsp_pkg::*;

    lsp_intervals_t intervals;
    lsp_mode_wr_t   mode_wr;

    logic             in_valid_reg, in_valid_next;
    logic [TimeW-1:0] in_now_reg;
    logic             out_valid_reg, out_valid_next;
    logic             out_level_reg;
    logic             led_next;
    logic             advance;

    lsp_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .intervals   (intervals),
        .mode_wr     (mode_wr)
    );

    lsp_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .now_ms    (in_now_reg),
        .intervals (intervals),
        .mode_wr   (mode_wr),
        .led_next  (led_next)
    );

    // Pipeline flow: input stage moves on when the result register frees up
    assign advance        = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready       = !in_valid_reg || advance;
    assign in_valid_next  = (s_tvalid && s_tready) || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_now_reg <= s_tdata[TimeW-1:0];
        end
        if (advance) begin
            out_level_reg <= led_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OutDataW-1){1'b0}}, out_level_reg};

    // A waiting poll reaches the empty result register next cycle
    a_fill_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("poll not moved into empty result register");

    // Input side stalls only when both stages are full and the sink stalls
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without back-pressure");

    // A taken result with nothing behind it leaves the output empty
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !in_valid_reg) |=> !m_tvalid)
        else $error("result repeated after drain");

endmodule
